// ----- rtl/core/keyword_token_counter_macros.svh -----
// Assertion helpers for the keyword token counter.
// Both expect clk and rst_n in scope.
`ifndef KEYWORD_TOKEN_COUNTER_MACROS_SVH
`define KEYWORD_TOKEN_COUNTER_MACROS_SVH

// Consequent must hold in the same cycle.
`define KTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the next cycle.
`define KTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ktc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ktc_pkg;

  localparam int NUM_ENTRIES_DEF  = 16;
  localparam int MAX_NAME_LEN_DEF = 16;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int CFG_W     = 5;
  localparam int CHAR_W    = 8;
  localparam int ENTRY_W   = 4;
  localparam int POS_W     = 4;
  localparam int OUT_CNT_W = 16;
  // widest internal address and entry count over the parameter range
  localparam int ADDR_W_MAX = 6;
  localparam int USED_W_MAX = 7;

  localparam logic [CFG_W-1:0] ENTRIES_RESET = 5'd16;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_TEXT = 1'b1;
  localparam logic [7:0] CHAR_EOD = 8'h00;
  localparam logic [7:0] CHAR_QM  = 8'h3F;
  localparam logic [7:0] CHAR_US  = 8'h5F;
  localparam logic [8:0] CASE_OFS = 9'd32;

  typedef struct packed {
    logic                command;
    logic [ENTRY_W-1:0]  entry;
    logic [POS_W-1:0]    position;
    logic [CHAR_W-1:0]   char_in;
  } ktc_in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]   entry_index;
    logic [OUT_CNT_W-1:0] count;
    logic                 last;
  } ktc_out_t;

  typedef struct packed {
    logic                  load_we;
    logic [ENTRY_W-1:0]    load_entry;
    logic [ADDR_W_MAX-1:0] load_addr;
    logic [CHAR_W-1:0]     load_char;
    logic [ADDR_W_MAX-1:0] rd_addr;
    logic                  step;
    logic                  tok_end;
    logic                  len_nz;
    logic                  at_max;
    logic [CHAR_W-1:0]     ch;
    logic [USED_W_MAX-1:0] used;
    logic                  shift;
    logic                  clear;
  } ktc_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REPORT = 2'b10
  } ktc_state_t;

  function automatic logic is_token_char(input logic [CHAR_W-1:0] c);
    is_token_char = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                    c == CHAR_QM || c == CHAR_US;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ktc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ktc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: a same-address write shows on the read port
  always_ff @(posedge clk) begin
    rdata_r <= (we && waddr == raddr) ? wdata : mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ktc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ktc_cell #(
  parameter int IDX          = 0,
  parameter int MAX_NAME_LEN = 16,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ktc_pkg::ktc_cell_ctrl_t ctrl,
  input  wire logic [COUNT_BITS-1:0]  cnt_in,
  output logic      [COUNT_BITS-1:0]  cnt_out
);

  import ktc_pkg::*;

  localparam int AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                  alive_r, alive_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]     name_ch;
  logic                  we;
  logic                  char_ok;
  logic                  ends;
  logic                  in_use;

  assign we = ctrl.load_we &&
              (USED_W_MAX'(ctrl.load_entry) == USED_W_MAX'(IDX));

  ktc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_NAME_LEN)
  ) u_name (
    .clk     (clk),
    .we      (we),
    .waddr   (AW'(ctrl.load_addr)),
    .wdata   (ctrl.load_char),
    .raddr   (AW'(ctrl.rd_addr)),
    .rdata_r (name_ch)
  );

  assign char_ok = !ctrl.at_max && name_ch != CHAR_EOD &&
                   ({1'b0, name_ch} == {1'b0, ctrl.ch} ||
                    {1'b0, name_ch} == ({1'b0, ctrl.ch} + CASE_OFS));
  assign ends    = ctrl.at_max || name_ch == CHAR_EOD;
  assign in_use  = USED_W_MAX'(IDX) < ctrl.used;

  always_comb begin
    alive_nxt = alive_r;
    cnt_nxt   = cnt_r;
    if (ctrl.step) begin
      alive_nxt = alive_r && char_ok;
    end
    if (ctrl.tok_end) begin
      alive_nxt = 1'b1;
      if (ctrl.len_nz && alive_r && in_use && ends && cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (ctrl.shift) begin
      cnt_nxt = cnt_in;
    end
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b1;
      cnt_r   <= '0;
    end else begin
      alive_r <= alive_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cnt_out = cnt_r;

endmodule

`default_nettype wire

// ----- rtl/core/keyword_token_counter.sv -----
// Load and text requests: one per cycle while idle, each taken by the cell row.
// End of document: the request starts the report, which registers the first count;
// then one count per cycle unless the output stalls, shifting down the cell row, one
// per entry in use (capped at the entry count); input is held off until the report ends.
// Reset (synchronous, rst_n low): counts zero, match flags set, token length zero,
// entries_in_use 16, output empty. Name characters stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module keyword_token_counter #(
  parameter int NUM_ENTRIES  = ktc_pkg::NUM_ENTRIES_DEF,
  parameter int MAX_NAME_LEN = ktc_pkg::MAX_NAME_LEN_DEF,
  parameter int COUNT_BITS   = ktc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire ktc_pkg::ktc_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output ktc_pkg::ktc_out_t              out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [ktc_pkg::CFG_W-1:0] cfg_data
);

  import ktc_pkg::*;

  `include "keyword_token_counter_macros.svh"

  localparam int AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int LW = $clog2(MAX_NAME_LEN + 1);
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int UW = $clog2(NUM_ENTRIES + 1);

  ktc_state_t         state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_r;
  logic [LW-1:0]      tok_len_r, tok_len_nxt;
  logic [IW-1:0]      rep_idx_r, rep_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  ktc_out_t           out_r, out_nxt;
  logic [UW-1:0]      used_eff;
  logic               acc, is_load, is_step, is_end, is_eod;
  logic               slot_free, rep_last, shift, clear;
  logic               load_ok;
  ktc_cell_ctrl_t     ctrl;
  logic [COUNT_BITS-1:0] cnt_chain [NUM_ENTRIES + 1];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign is_load   = acc && in_data.command == CMD_LOAD;
  assign is_step   = acc && in_data.command == CMD_TEXT && is_token_char(in_data.char_in);
  assign is_end    = acc && in_data.command == CMD_TEXT && !is_token_char(in_data.char_in);
  assign is_eod    = is_end && in_data.char_in == CHAR_EOD;

  // registers above the entry count act as the full count
  assign used_eff = (USED_W_MAX'(cfg_r) > USED_W_MAX'(NUM_ENTRIES)) ?
                    UW'(NUM_ENTRIES) : UW'(cfg_r);

  assign load_ok = (USED_W_MAX'(in_data.entry) < USED_W_MAX'(NUM_ENTRIES)) &&
                   (USED_W_MAX'(in_data.position) < USED_W_MAX'(MAX_NAME_LEN));

  always_comb begin
    tok_len_nxt = tok_len_r;
    if (is_step && tok_len_r != LW'(MAX_NAME_LEN)) begin
      tok_len_nxt = tok_len_r + 1'b1;
    end
    if (is_end) begin
      tok_len_nxt = '0;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign rep_last  = (UW'(rep_idx_r) + UW'(1)) == used_eff;

  always_comb begin
    state_nxt     = state_r;
    rep_idx_nxt   = rep_idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    shift         = 1'b0;
    clear         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (is_eod) begin
          rep_idx_nxt = '0;
          if (used_eff != '0) begin
            state_nxt = ST_REPORT;
          end else begin
            clear = 1'b1;
          end
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.entry_index = ENTRY_W'(rep_idx_r);
          out_nxt.count       = OUT_CNT_W'(cnt_chain[0]);
          out_nxt.last        = rep_last;
          shift               = 1'b1;
          rep_idx_nxt         = rep_idx_r + 1'b1;
          if (rep_last) begin
            // drop whatever the unreported cells still hold
            clear     = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.load_we    = is_load && load_ok;
    ctrl.load_entry = in_data.entry;
    ctrl.load_addr  = ADDR_W_MAX'(in_data.position);
    ctrl.load_char  = in_data.char_in;
    ctrl.rd_addr    = ADDR_W_MAX'(tok_len_nxt[AW-1:0]);
    ctrl.step       = is_step;
    ctrl.tok_end    = is_end;
    ctrl.len_nz     = tok_len_r != '0;
    ctrl.at_max     = tok_len_r == LW'(MAX_NAME_LEN);
    ctrl.ch         = in_data.char_in;
    ctrl.used       = USED_W_MAX'(used_eff);
    ctrl.shift      = shift;
    ctrl.clear      = clear;
  end

  assign cnt_chain[NUM_ENTRIES] = '0;

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    ktc_cell #(
      .IDX          (i),
      .MAX_NAME_LEN (MAX_NAME_LEN),
      .COUNT_BITS   (COUNT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .cnt_in  (cnt_chain[i + 1]),
      .cnt_out (cnt_chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= ENTRIES_RESET;
      tok_len_r   <= '0;
      rep_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok_len_r   <= tok_len_nxt;
      rep_idx_r   <= rep_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `KTC_ASSERT_NEXT(a_eod_starts_report, is_eod && used_eff != '0, state_r == ST_REPORT, "report did not start")
  `KTC_ASSERT_NOW(a_rep_idx_range, state_r == ST_REPORT, UW'(rep_idx_r) < used_eff, "report index past entries in use")
  `KTC_ASSERT_NEXT(a_report_fills_slot, state_r == ST_REPORT && slot_free, out_valid_r, "free output slot not filled during report")

endmodule

`default_nettype wire
